// ----- rtl/core/ramdac_hidden_reg_ext_palette_macros.svh -----
// assertion macros for the ramdac hidden register block
// used by the top level; expects aclk and aresetn in scope
`ifndef RAMDAC_HIDDEN_REG_EXT_PALETTE_MACROS_SVH
`define RAMDAC_HIDDEN_REG_EXT_PALETTE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RDHR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RDHR_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RDHR_ASSERT(lbl, prop, msg)
`define RDHR_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/rdhr_pkg.sv -----
// shared types, constants and helper functions for the ramdac hidden register block
// no dependencies
`default_nettype none

package rdhr_pkg;

    localparam int EXT_ENTRIES = 16;
    localparam int EXT_IDX_W   = $clog2(EXT_ENTRIES);
    localparam int ROW_W       = 24;

    localparam logic [2:0] ARM_READS = 3'd4;

    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_EXT_EN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FMT_MSK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FMT_565 = 2'd3;

    localparam logic [7:0] FMT_MASK_RST   = 8'h0f;
    localparam logic [7:0] FMT_565_RST    = 8'h01;
    localparam logic [7:0] PIXEL_MASK_RST = 8'hff;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;
    localparam logic [7:0] NOT_READ_BYTE  = 8'hff;

    localparam logic [2:0] FMT_VGA = 3'd0;
    localparam logic [2:0] FMT_8   = 3'd1;
    localparam logic [2:0] FMT_15  = 3'd2;
    localparam logic [2:0] FMT_16  = 3'd3;
    localparam logic [2:0] FMT_24  = 3'd4;
    localparam logic [2:0] FMT_32  = 3'd5;

    localparam logic [2:0] DEPTH_16_DBL = 3'd1;
    localparam logic [2:0] DEPTH_24     = 3'd2;
    localparam logic [2:0] DEPTH_16     = 3'd3;
    localparam logic [2:0] DEPTH_32     = 3'd4;

    localparam logic [1:0] PHASE_R = 2'd0;
    localparam logic [1:0] PHASE_G = 2'd1;
    localparam logic [1:0] PHASE_B = 2'd2;
    localparam logic [1:0] PHASE_X = 2'd3;

    typedef enum logic [2:0] {
        REQ_MASK_RD    = 3'd0,
        REQ_MASK_WR    = 3'd1,
        REQ_DATA_RD    = 3'd2,
        REQ_DATA_WR    = 3'd3,
        REQ_SET_RD_IDX = 3'd4,
        REQ_SET_WR_IDX = 3'd5,
        REQ_LOOKUP     = 3'd6
    } req_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
    } status_t;

    function automatic logic [7:0] expand6(input logic [7:0] v);
        return {v[5:0], v[5:4]};
    endfunction

    function automatic logic [2:0] decode_format(
        input logic [7:0] mode,
        input logic [7:0] hidden,
        input logic [7:0] fmask,
        input logic [7:0] f565
    );
        logic [2:0] fmt;
        if (!mode[0]) begin
            fmt = FMT_VGA;
        end else begin
            unique case (mode[3:1])
                DEPTH_16_DBL, DEPTH_16: fmt = ((hidden & fmask) == f565) ? FMT_16 : FMT_15;
                DEPTH_24:               fmt = FMT_24;
                DEPTH_32:               fmt = FMT_32;
                default:                fmt = FMT_8;
            endcase
        end
        return fmt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rdhr_ctrl.sv -----
// request sequencer: accept with palette read, wait for a free result register, result hand-off
// depends on rdhr_pkg
`default_nettype none

module rdhr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             m_tready,
    input  wire rdhr_pkg::status_t status,
    output logic                  s_tready,
    output rdhr_pkg::cmd_t        cmd
);
    import rdhr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_free;

    assign out_free = !status.out_valid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.commit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/rdhr_dp.sv -----
// datapath: config registers, dac state, extended palette memory, result register
// depends on rdhr_pkg
`default_nettype none

module rdhr_dp #(
    parameter logic [2:0] ARM_READS = rdhr_pkg::ARM_READS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rdhr_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [rdhr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic [rdhr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic [rdhr_pkg::S_TUSER_W-1:0]      s_tuser,
    input  wire rdhr_pkg::cmd_t                      cmd,
    input  wire logic                                m_tready,
    output rdhr_pkg::status_t                        status,
    output logic                                     m_tvalid,
    output logic [rdhr_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic [rdhr_pkg::M_TUSER_W-1:0]           m_tuser
);
    import rdhr_pkg::*;

    // configuration
    logic       ext_en_reg;
    logic [7:0] mode_reg;
    logic [7:0] fmt_mask_reg;
    logic [7:0] fmt_565_reg;

    // dac state
    logic [2:0] arm_count_reg,  arm_count_next;
    logic [7:0] hidden_val_reg, hidden_val_next;
    logic [7:0] pixel_mask_reg, pixel_mask_next;
    logic [7:0] load0_reg,      load0_next;
    logic [7:0] load1_reg,      load1_next;
    logic [1:0] phase_reg,      phase_next;
    logic [7:0] rd_index_reg,   rd_index_next;
    logic [7:0] wr_index_reg,   wr_index_next;
    logic       read_mode_reg,  read_mode_next;

    // held request
    logic [2:0] req_reg;
    logic [7:0] wdata_reg;
    logic [7:0] idx_reg;

    // palette memory, one rgb row per entry
    logic [ROW_W-1:0]       pal_mem [EXT_ENTRIES];
    logic [EXT_ENTRIES-1:0] row_valid_reg;
    logic [ROW_W-1:0]       rd_row_reg;
    logic                   rd_row_valid_reg;
    logic [EXT_IDX_W-1:0]   rd_addr;
    logic                   mem_we;

    // result
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_tdata_reg;
    logic [M_TUSER_W-1:0] out_tuser_reg;

    logic [ROW_W-1:0] row;
    logic [1:0]       ph;
    logic [7:0]       row_byte;
    logic [7:0]       res_rdata;
    logic             res_handled;
    logic [31:0]      res_argb;
    logic             res_changed;
    logic [2:0]       res_fmt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_en_reg   <= 1'b0;
            mode_reg     <= 8'h00;
            fmt_mask_reg <= FMT_MASK_RST;
            fmt_565_reg  <= FMT_565_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_EXT_EN:  ext_en_reg   <= cfg_wr_data[0];
                CFG_MODE:    mode_reg     <= cfg_wr_data;
                CFG_FMT_MSK: fmt_mask_reg <= cfg_wr_data;
                CFG_FMT_565: fmt_565_reg  <= cfg_wr_data;
                default:     ext_en_reg   <= ext_en_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= s_tuser[2:0];
            wdata_reg <= s_tdata[7:0];
            idx_reg   <= s_tdata[15:8];
        end
    end

    assign rd_addr = (s_tuser[2:0] == REQ_LOOKUP) ? s_tdata[8 +: EXT_IDX_W]
                                                  : rd_index_reg[EXT_IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_row_reg <= pal_mem[rd_addr];
        end
        if (cmd.commit && mem_we) begin
            pal_mem[wr_index_reg[EXT_IDX_W-1:0]] <= {load0_reg, load1_reg, wdata_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg    <= '0;
            rd_row_valid_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                rd_row_valid_reg <= row_valid_reg[rd_addr];
            end
            if (cmd.commit && mem_we) begin
                row_valid_reg[wr_index_reg[EXT_IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    assign row = rd_row_valid_reg ? rd_row_reg : '0;
    assign ph  = (phase_reg == PHASE_X) ? PHASE_R : phase_reg;

    always_comb begin
        unique case (ph)
            PHASE_R: row_byte = row[23:16];
            PHASE_G: row_byte = row[15:8];
            default: row_byte = row[7:0];
        endcase
    end

    always_comb begin
        arm_count_next  = arm_count_reg;
        hidden_val_next = hidden_val_reg;
        pixel_mask_next = pixel_mask_reg;
        load0_next      = load0_reg;
        load1_next      = load1_reg;
        phase_next      = phase_reg;
        rd_index_next   = rd_index_reg;
        wr_index_next   = wr_index_reg;
        read_mode_next  = read_mode_reg;
        mem_we          = 1'b0;
        res_rdata       = 8'h00;
        res_handled     = 1'b1;
        res_argb        = 32'h0;
        res_changed     = 1'b0;
        unique case (req_reg)
            REQ_MASK_RD: begin
                if (arm_count_reg >= ARM_READS) begin
                    arm_count_next = 3'd0;
                    res_rdata      = hidden_val_reg;
                end else begin
                    arm_count_next = arm_count_reg + 3'd1;
                    res_rdata      = pixel_mask_reg;
                end
            end
            REQ_MASK_WR: begin
                if (arm_count_reg == ARM_READS) begin
                    hidden_val_next = wdata_reg;
                    res_changed     = 1'b1;
                end else begin
                    pixel_mask_next = wdata_reg;
                end
                arm_count_next = 3'd0;
            end
            REQ_DATA_RD: begin
                if (!ext_en_reg) begin
                    res_handled = 1'b0;
                end else if (read_mode_reg) begin
                    res_rdata = row_byte;
                    if (ph == PHASE_B) begin
                        phase_next    = PHASE_R;
                        rd_index_next = rd_index_reg + 8'd1;
                    end else begin
                        phase_next = ph + 2'd1;
                    end
                end else begin
                    res_rdata = NOT_READ_BYTE;
                end
            end
            REQ_DATA_WR: begin
                if (!ext_en_reg) begin
                    res_handled = 1'b0;
                end else if (!read_mode_reg) begin
                    unique case (ph)
                        PHASE_R: begin
                            load0_next = wdata_reg;
                            phase_next = PHASE_G;
                        end
                        PHASE_G: begin
                            load1_next = wdata_reg;
                            phase_next = PHASE_B;
                        end
                        default: begin
                            mem_we        = 1'b1;
                            phase_next    = PHASE_R;
                            wr_index_next = wr_index_reg + 8'd1;
                            res_changed   = 1'b1;
                        end
                    endcase
                end
            end
            REQ_SET_RD_IDX: begin
                rd_index_next  = idx_reg;
                phase_next     = PHASE_R;
                read_mode_next = 1'b1;
            end
            REQ_SET_WR_IDX: begin
                wr_index_next  = idx_reg;
                phase_next     = PHASE_R;
                read_mode_next = 1'b0;
            end
            REQ_LOOKUP: begin
                res_argb = {ALPHA_OPAQUE, expand6(row[23:16]), expand6(row[15:8]),
                            expand6(row[7:0])};
            end
            default: begin
                res_handled = 1'b0;
            end
        endcase
        res_fmt = decode_format(mode_reg, hidden_val_next, fmt_mask_reg, fmt_565_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_count_reg  <= 3'd0;
            hidden_val_reg <= 8'h00;
            pixel_mask_reg <= PIXEL_MASK_RST;
            load0_reg      <= 8'h00;
            load1_reg      <= 8'h00;
            phase_reg      <= PHASE_R;
            rd_index_reg   <= 8'h00;
            wr_index_reg   <= 8'h00;
            read_mode_reg  <= 1'b0;
        end else if (cmd.commit) begin
            arm_count_reg  <= arm_count_next;
            hidden_val_reg <= hidden_val_next;
            pixel_mask_reg <= pixel_mask_next;
            load0_reg      <= load0_next;
            load1_reg      <= load1_next;
            phase_reg      <= phase_next;
            rd_index_reg   <= rd_index_next;
            wr_index_reg   <= wr_index_next;
            read_mode_reg  <= read_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_tdata_reg <= {4'h0, res_changed, res_argb, res_fmt, res_rdata};
            out_tuser_reg <= res_handled;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_tdata_reg;
    assign m_tuser          = out_tuser_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ramdac_hidden_reg_ext_palette.sv -----
// ramdac hidden register with extended palette: each request goes from accept to result
// by first reading the palette row into its output register on accept, and then
// updating the dac state and loading the result register once that register is free;
// a new request is taken only after the result is loaded, so requests never overlap.
// four mask reads in a row arm the hidden register. no clearing pass.
// depends on rdhr_pkg, rdhr_ctrl, rdhr_dp and the assertion macro header
`default_nettype none

`include "ramdac_hidden_reg_ext_palette_macros.svh"

module ramdac_hidden_reg_ext_palette #(
    parameter logic [2:0] ARM_READS = rdhr_pkg::ARM_READS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rdhr_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [rdhr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // write_data[7:0], entry_index[15:8]
    input  wire logic [rdhr_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  wire logic [rdhr_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // read_data[7:0], pixel_format[10:8], argb_color[42:11], display_changed[43]
    output logic [rdhr_pkg::M_TDATA_W-1:0]       m_tdata,
    // handled[0]
    output logic [rdhr_pkg::M_TUSER_W-1:0]       m_tuser
);
    import rdhr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    res_empty;

    rdhr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rdhr_dp #(
        .ARM_READS (ARM_READS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cmd          (cmd),
        .m_tready     (m_tready),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    assign res_empty = (m_tdata[7:0] == 8'h00) && (m_tdata[42:11] == 32'h0);

    `RDHR_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "request while busy")
    `RDHR_ASSERT(a_unhandled_zero, m_tvalid && !m_tuser[0] |-> res_empty, "unhandled with data")
    `RDHR_ASSERT(a_change_handled, m_tvalid && m_tdata[43] |-> m_tuser[0], "change unhandled")
    `RDHR_ASSERT_NORST(a_reset_idle, !aresetn |=> !m_tvalid && !cmd.commit, "busy after reset")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking bench for ramdac_hidden_reg_ext_palette: random requests with an inline
// predictor of the hidden register, the pixel mask and the extended palette.
// depends on rdhr_pkg and the rtl under rtl/core
module tb;
    import rdhr_pkg::*;

    localparam logic [2:0] REQ_UNDEF = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] wdata;
        logic [7:0] index;
    } dac_req_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        handled;
        logic [2:0]  fmt;
        logic [31:0] argb;
        logic        changed;
    } dac_reply_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata      = '0;
    logic [S_TUSER_W-1:0]  s_tuser      = '0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    dac_req_t   req_queue[$];
    dac_reply_t awaited_replies[$];
    dac_req_t   cur_req;
    int         n_queued     = 0;
    int         n_replied    = 0;
    int         n_errors     = 0;
    int         stall_cycles = 0;
    bit         calm         = 1'b0;

    // predictor copy of configuration and dac state
    logic       pal_en;
    logic [7:0] mode_reg, fmt_mask, fmt_565;
    logic [2:0] arm_cnt;
    logic [7:0] hidden, pix_mask;
    logic [7:0] palette [EXT_ENTRIES*3];
    logic [7:0] load_bytes [2];
    logic [1:0] phase;
    logic [7:0] rd_ptr, wr_ptr;
    logic       rd_mode;

    ramdac_hidden_reg_ext_palette dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] widen6(input logic [7:0] v);
        logic [7:0] x;
        x = v & 8'h3f;
        return (x << 2) | (x >> 4);
    endfunction

    function automatic logic [2:0] pixel_format_now();
        if (!mode_reg[0]) begin
            return FMT_VGA;
        end
        case (mode_reg[3:1])
            DEPTH_16_DBL, DEPTH_16: return ((hidden & fmt_mask) == fmt_565) ? FMT_16 : FMT_15;
            DEPTH_24:               return FMT_24;
            DEPTH_32:               return FMT_32;
            default:                return FMT_8;
        endcase
    endfunction

    function automatic dac_reply_t dac_access(input dac_req_t rq);
        dac_reply_t r;
        int         base;
        logic [1:0] ph;
        r = '0;
        r.handled = 1'b1;
        case (rq.kind)
            REQ_MASK_RD: begin
                if (int'(arm_cnt) + 1 > int'(ARM_READS)) begin
                    arm_cnt = '0;
                    r.rdata = hidden;
                end else begin
                    arm_cnt = arm_cnt + 3'd1;
                    r.rdata = pix_mask;
                end
            end
            REQ_MASK_WR: begin
                if (arm_cnt == ARM_READS) begin
                    hidden = rq.wdata;
                    r.changed = 1'b1;
                end else begin
                    pix_mask = rq.wdata;
                end
                arm_cnt = '0;
            end
            REQ_DATA_RD: begin
                if (!pal_en) begin
                    r.handled = 1'b0;
                end else begin
                    r.rdata = NOT_READ_BYTE;
                    if (rd_mode) begin
                        ph = (phase < 2'd3) ? phase : PHASE_R;
                        r.rdata = palette[int'(rd_ptr[3:0]) * 3 + int'(ph)];
                        if (ph == PHASE_B) begin
                            phase = PHASE_R;
                            rd_ptr = rd_ptr + 8'd1;
                        end else begin
                            phase = ph + 2'd1;
                        end
                    end
                end
            end
            REQ_DATA_WR: begin
                if (!pal_en) begin
                    r.handled = 1'b0;
                end else if (!rd_mode) begin
                    ph = (phase < 2'd3) ? phase : PHASE_R;
                    if (ph != PHASE_B) begin
                        load_bytes[ph[0]] = rq.wdata;
                        phase = ph + 2'd1;
                    end else begin
                        base = int'(wr_ptr[3:0]) * 3;
                        palette[base]     = load_bytes[0];
                        palette[base + 1] = load_bytes[1];
                        palette[base + 2] = rq.wdata;
                        phase = PHASE_R;
                        wr_ptr = wr_ptr + 8'd1;
                        r.changed = 1'b1;
                    end
                end
            end
            REQ_SET_RD_IDX: begin
                rd_ptr = rq.index;
                phase = PHASE_R;
                rd_mode = 1'b1;
            end
            REQ_SET_WR_IDX: begin
                wr_ptr = rq.index;
                phase = PHASE_R;
                rd_mode = 1'b0;
            end
            REQ_LOOKUP: begin
                base = int'(rq.index[3:0]) * 3;
                r.argb = {ALPHA_OPAQUE, widen6(palette[base]), widen6(palette[base + 1]),
                          widen6(palette[base + 2])};
            end
            default: begin
                r.handled = 1'b0;
            end
        endcase
        r.fmt = pixel_format_now();
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_replies.push_back(dac_access(cur_req));
            end
            if (!s_tvalid || s_tready) begin
                if (req_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
                    cur_req = req_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_req.index, cur_req.wdata};
                    s_tuser  <= cur_req.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        dac_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_replied++;
                if (awaited_replies.size() == 0) begin
                    n_errors++;
                    $display("%0t unexpected result: expected none, actual %0h", $time, m_tdata);
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("read_data", 32'(want.rdata), 32'(m_tdata[7:0]));
                    check_field("handled", 32'(want.handled), 32'(m_tuser[0]));
                    check_field("pixel_format", 32'(want.fmt), 32'(m_tdata[10:8]));
                    check_field("argb_color", want.argb, m_tdata[42:11]);
                    check_field("display_changed", 32'(want.changed), 32'(m_tdata[43]));
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || n_replied == n_queued) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void push_req(input logic [2:0] kind, input logic [7:0] wdata,
                                     input logic [7:0] index);
        dac_req_t rq;
        rq.kind  = kind;
        rq.wdata = wdata;
        rq.index = index;
        req_queue.push_back(rq);
        n_queued++;
    endfunction

    task automatic wait_idle();
        while (n_replied != n_queued) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            CFG_EXT_EN:  pal_en   = val[0];
            CFG_MODE:    mode_reg = val;
            CFG_FMT_MSK: fmt_mask = val;
            CFG_FMT_565: fmt_565  = val;
            default: ;
        endcase
    endtask

    task automatic write_cfg(input logic en, input logic [7:0] mode, input logic [7:0] fmask,
                             input logic [7:0] f565);
        wait_idle();
        write_reg(CFG_EXT_EN, {7'($urandom), en});
        write_reg(CFG_MODE, mode);
        write_reg(CFG_FMT_MSK, fmask);
        write_reg(CFG_FMT_565, f565);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic fill_random(input int n);
        int target, k, nbytes;
        target = n_queued + n;
        while (n_queued < target) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // arm sequence, sometimes with the wrong number of reads
                    k = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : int'(ARM_READS);
                    repeat (k) push_req(REQ_MASK_RD, 8'($urandom), 8'($urandom));
                    if ($urandom_range(0, 3) == 0) begin
                        push_req($urandom_range(0, 1) ? REQ_DATA_RD : REQ_LOOKUP,
                                 8'($urandom), 8'($urandom));
                    end
                    if ($urandom_range(0, 1)) begin
                        push_req(REQ_MASK_WR, $urandom_range(0, 1) ?
                                 ((8'($urandom) & ~fmt_mask) | fmt_565) : 8'($urandom),
                                 8'($urandom));
                    end else begin
                        push_req(REQ_MASK_RD, 8'($urandom), 8'($urandom));
                    end
                end
                2, 3: begin
                    push_req(REQ_SET_WR_IDX, 8'($urandom), 8'($urandom));
                    nbytes = 3 * $urandom_range(1, 4);
                    if ($urandom_range(0, 5) == 0) nbytes = nbytes - $urandom_range(1, 2);
                    repeat (nbytes) push_req(REQ_DATA_WR, 8'($urandom), 8'($urandom));
                end
                4, 5: begin
                    push_req(REQ_SET_RD_IDX, 8'($urandom), 8'($urandom));
                    nbytes = 3 * $urandom_range(1, 4);
                    if ($urandom_range(0, 5) == 0) nbytes = nbytes - $urandom_range(1, 2);
                    repeat (nbytes) push_req(REQ_DATA_RD, 8'($urandom), 8'($urandom));
                end
                6: begin
                    repeat ($urandom_range(1, 4)) push_req(REQ_LOOKUP, 8'($urandom),
                                                           8'($urandom));
                end
                7: begin
                    push_req(REQ_MASK_WR, 8'($urandom), 8'($urandom));
                    push_req(REQ_MASK_RD, 8'($urandom), 8'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 3)) push_req(3'($urandom_range(0, 7)),
                                                           8'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        pal_en   = 1'b0;
        mode_reg = 8'h00;
        fmt_mask = FMT_MASK_RST;
        fmt_565  = FMT_565_RST;
        arm_cnt  = '0;
        hidden   = 8'h00;
        pix_mask = PIXEL_MASK_RST;
        foreach (palette[i]) palette[i] = 8'h00;
        load_bytes[0] = 8'h00;
        load_bytes[1] = 8'h00;
        phase   = PHASE_R;
        rd_ptr  = 8'h00;
        wr_ptr  = 8'h00;
        rd_mode = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: palette disabled, plain vga
        push_req(REQ_DATA_RD, 8'h00, 8'h00);
        push_req(REQ_DATA_WR, 8'haa, 8'h55);
        push_req(REQ_UNDEF, 8'hff, 8'hff);
        push_req(REQ_LOOKUP, 8'h00, 8'h00);
        push_req(REQ_MASK_WR, 8'h00, 8'h00);
        repeat (int'(ARM_READS) + 1) push_req(REQ_MASK_RD, 8'h00, 8'h00);

        write_cfg(1'b1, 8'h03, 8'h0f, 8'h01);
        repeat (int'(ARM_READS)) push_req(REQ_MASK_RD, 8'hff, 8'hff);
        push_req(REQ_MASK_WR, 8'h01, 8'h00);
        // write index past the palette wraps onto entry 15
        push_req(REQ_SET_WR_IDX, 8'h00, 8'hff);
        push_req(REQ_DATA_WR, 8'h3f, 8'h00);
        push_req(REQ_DATA_WR, 8'h00, 8'h00);
        push_req(REQ_DATA_WR, 8'hff, 8'h00);
        push_req(REQ_DATA_RD, 8'h00, 8'h00);
        push_req(REQ_SET_RD_IDX, 8'h00, 8'h0f);
        repeat (3) push_req(REQ_DATA_RD, 8'h00, 8'h00);
        push_req(REQ_DATA_WR, 8'h12, 8'h00);
        push_req(REQ_LOOKUP, 8'h00, 8'hff);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: write_cfg(1'b1, 8'hff, 8'hff, 8'hff);
                1: write_cfg(1'b0, 8'h00, 8'h00, 8'h00);
                2: write_cfg(1'b1, 8'h07, 8'h0f, 8'h01);
                3: write_cfg(1'b1, 8'h05, 8'h03, 8'h02);
                4: write_cfg(1'b1, 8'h09, 8'($urandom), 8'($urandom));
                5: write_cfg(1'b1, 8'h03, 8'h00, 8'h00);
                6: write_cfg(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                             8'($urandom));
                default: write_cfg(1'b1, 8'h01, 8'hff, 8'h00);
            endcase
            calm = (p == 3);
            fill_random(PHASE_ITEMS);
        end

        wait_idle();
        calm = 1'b0;
        repeat (10) @(posedge aclk);
        if (n_errors == 0 && awaited_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
